FILE: sv/tvs_pkg.sv
package tvs_pkg;

    localparam int DEF_MAX_WIDTH    = 32;
    localparam int DEF_MAX_HEIGHT   = 32;
    localparam int DEF_MAX_DEPTH    = 32;
    localparam int DEF_MAX_CHANNELS = 4;

    localparam int RESULT_LIMIT = 4;

    localparam logic CMD_WRITE  = 1'b0;
    localparam logic CMD_SAMPLE = 1'b1;

    localparam logic [1:0] CFG_VOL_WIDTH    = 2'd0;
    localparam logic [1:0] CFG_VOL_HEIGHT   = 2'd1;
    localparam logic [1:0] CFG_VOL_DEPTH    = 2'd2;
    localparam logic [1:0] CFG_NUM_CHANNELS = 2'd3;

    localparam logic [5:0] RST_VOL_DIM      = 6'd32;
    localparam logic [2:0] RST_NUM_CHANNELS = 3'd1;

    // per-channel schedule: corner reads on steps 0..7, lerps below
    localparam logic [3:0] STEP_READ_END = 4'd8;
    localparam logic [3:0] STEP_Y0       = 4'd5;
    localparam logic [3:0] STEP_Y1       = 4'd9;
    localparam logic [3:0] STEP_Z        = 4'd10;

    typedef struct packed {
        logic               cmd;
        logic [4:0]         voxel_x;
        logic [4:0]         voxel_y;
        logic [4:0]         voxel_z;
        logic [1:0]         voxel_channel;
        logic signed [15:0] voxel_value;
        logic signed [23:0] sample_x;
        logic signed [23:0] sample_y;
        logic signed [23:0] sample_z;
    } t_req;

    typedef struct packed {
        logic [1:0]         out_channel;
        logic signed [15:0] out_value;
        logic               out_last;
    } t_rsp;

    // a*(256-f) + b*f, rounded, floor shift by 8
    function automatic logic signed [15:0] lerp(
        input logic signed [15:0] a,
        input logic signed [15:0] b,
        input logic        [7:0]  f
    );
        logic signed [16:0] d;
        logic signed [25:0] p;
        logic signed [25:0] t;
        d = 17'(b) - 17'(a);
        p = 26'(d) * 26'($signed({1'b0, f}));
        t = p + (26'(a) <<< 8) + 26'sd128;
        return t[23:8];
    endfunction

endpackage

FILE: sv/tvs_channels.sv
interface tvs_req_if;
    import tvs_pkg::*;
    logic valid;
    logic ready;
    t_req data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface tvs_rsp_if;
    import tvs_pkg::*;
    logic valid;
    logic ready;
    t_rsp data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface tvs_cfg_if;
    logic       valid;
    logic       ready;
    logic [1:0] index;
    logic [5:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

FILE: sv/trilinear_volume_sampler_core.sv
// trilinear volume sampler
// i_req: one request per command. cmd write stores voxel_value at
//   (voxel_channel, voxel_z, voxel_y, voxel_x) and gives no response. cmd
//   sample interpolates the volume at the Q15.8 point
//   (sample_x, sample_y, sample_z) and gives one response per channel.
// o_rsp: out_channel, out_value, out_last; out_last marks the final channel.
// i_cfg: register writes (index 0 width, 1 height, 2 depth, 3 channels),
//   always ready, to be issued only while the block is idle.
// a sample walks its channels one after another. each channel runs through
//   eight corner reads from the single voxel memory, one per cycle, with the
//   x lerps and the first y lerp interleaved, then the second y lerp and the
//   z lerp. the block stays busy until the last channel's result is loaded
//   into the output register.
// i_req is not ready while a sample is in progress.
// a finished channel waits in the output register; if the receiver stalls,
//   the next channel's z lerp waits until that register is free.
// reset restores the registers (32 x 32 x 32, one channel), clears the
//   control state and drops o_rsp.valid; the voxel memory is not cleared and
//   must be written before it is read.
module trilinear_volume_sampler_core #(
    parameter int MAX_WIDTH    = tvs_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT   = tvs_pkg::DEF_MAX_HEIGHT,
    parameter int MAX_DEPTH    = tvs_pkg::DEF_MAX_DEPTH,
    parameter int MAX_CHANNELS = tvs_pkg::DEF_MAX_CHANNELS
) (
    input logic        i_clk,
    input logic        i_rst_n,
    tvs_req_if.sink    i_req,
    tvs_rsp_if.source  o_rsp,
    tvs_cfg_if.sink    i_cfg
);
    import tvs_pkg::*;

    localparam int XW     = $clog2(MAX_WIDTH);
    localparam int YW     = $clog2(MAX_HEIGHT);
    localparam int ZW     = $clog2(MAX_DEPTH);
    localparam int CW     = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int AW     = CW + ZW + YW + XW;
    localparam int DEPTH  = 2 ** AW;
    localparam int CH_LIM = (MAX_CHANNELS < RESULT_LIMIT) ? MAX_CHANNELS : RESULT_LIMIT;

    logic [15:0] mem [DEPTH];

    logic [5:0] r_vol_width;
    logic [5:0] r_vol_height;
    logic [5:0] r_vol_depth;
    logic [2:0] r_num_ch;

    logic               r_busy;
    logic [3:0]         r_step;
    logic [1:0]         r_ch;
    logic signed [15:0] r_x0;
    logic signed [15:0] r_y0;
    logic signed [15:0] r_z0;
    logic [7:0]         r_fx;
    logic [7:0]         r_fy;
    logic [7:0]         r_fz;

    logic signed [15:0] r_rd_data;
    logic               r_rd_in;
    logic signed [15:0] r_ca;
    logic signed [15:0] r_e0;
    logic signed [15:0] r_e1;
    logic signed [15:0] r_f0;
    logic signed [15:0] r_f1;

    logic r_out_valid;
    t_rsp r_out;

    logic               req_fire;
    logic               wr_en;
    logic [AW-1:0]      wr_addr;
    logic [AW-1:0]      rd_addr;
    logic signed [16:0] cx;
    logic signed [16:0] cy;
    logic signed [16:0] cz;
    logic [15:0]        w_lim;
    logic [15:0]        h_lim;
    logic [15:0]        d_lim;
    logic               corner_in;
    logic [2:0]         nch;
    logic               ch_last;
    logic signed [15:0] cv;
    logic signed [15:0] x_res;
    logic               is_z;
    logic signed [15:0] yz_res;
    logic               out_fire;

    assign i_cfg.ready = 1'b1;
    assign i_req.ready = !r_busy;
    assign req_fire    = i_req.valid && !r_busy;

    // dimension limits and channel count
    always_comb begin
        w_lim = (32'(r_vol_width) > MAX_WIDTH) ? 16'(MAX_WIDTH) : 16'(r_vol_width);
        h_lim = (32'(r_vol_height) > MAX_HEIGHT) ? 16'(MAX_HEIGHT) : 16'(r_vol_height);
        d_lim = (32'(r_vol_depth) > MAX_DEPTH) ? 16'(MAX_DEPTH) : 16'(r_vol_depth);
        if (r_num_ch == 3'd0) begin
            nch = 3'd1;
        end else if (32'(r_num_ch) > CH_LIM) begin
            nch = 3'(CH_LIM);
        end else begin
            nch = r_num_ch;
        end
        ch_last = ((3'(r_ch) + 3'd1) == nch);
    end

    // voxel write path
    always_comb begin
        wr_en = req_fire && (i_req.data.cmd == CMD_WRITE)
            && (32'(i_req.data.voxel_x) < MAX_WIDTH)
            && (32'(i_req.data.voxel_y) < MAX_HEIGHT)
            && (32'(i_req.data.voxel_z) < MAX_DEPTH)
            && (32'(i_req.data.voxel_channel) < MAX_CHANNELS);
        wr_addr = {CW'(i_req.data.voxel_channel), ZW'(i_req.data.voxel_z),
                   YW'(i_req.data.voxel_y), XW'(i_req.data.voxel_x)};
    end

    // corner address, step bit 0 picks x1, bit 1 y1, bit 2 z1
    always_comb begin
        cx = r_step[0] ? (17'(r_x0) + 17'sd1) : 17'(r_x0);
        cy = r_step[1] ? (17'(r_y0) + 17'sd1) : 17'(r_y0);
        cz = r_step[2] ? (17'(r_z0) + 17'sd1) : 17'(r_z0);
        corner_in = !cx[16] && (cx[15:0] < w_lim)
                 && !cy[16] && (cy[15:0] < h_lim)
                 && !cz[16] && (cz[15:0] < d_lim);
        rd_addr = {CW'(r_ch), cz[ZW-1:0], cy[YW-1:0], cx[XW-1:0]};
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= i_req.data.voxel_value;
        end
        r_rd_data <= mem[rd_addr];
        r_rd_in   <= corner_in;
    end

    // lerp units
    always_comb begin
        cv     = r_rd_in ? r_rd_data : 16'sd0;
        x_res  = lerp(r_ca, cv, r_fx);
        is_z   = (r_step == STEP_Z);
        yz_res = is_z ? lerp(r_f0, r_f1, r_fz) : lerp(r_e0, r_e1, r_fy);
        out_fire = r_busy && is_z && (!r_out_valid || o_rsp.ready);
    end

    always_ff @(posedge i_clk) begin
        if (r_busy && r_step != 4'd0 && r_step <= STEP_READ_END) begin
            if (r_step[0]) begin
                r_ca <= cv;
            end else if (r_step[1]) begin
                r_e0 <= x_res;
            end else begin
                r_e1 <= x_res;
            end
        end
        if (r_busy && r_step == STEP_Y0) begin
            r_f0 <= yz_res;
        end
        if (r_busy && r_step == STEP_Y1) begin
            r_f1 <= yz_res;
        end
        if (req_fire && i_req.data.cmd == CMD_SAMPLE) begin
            r_x0 <= i_req.data.sample_x[23:8];
            r_y0 <= i_req.data.sample_y[23:8];
            r_z0 <= i_req.data.sample_z[23:8];
            r_fx <= i_req.data.sample_x[7:0];
            r_fy <= i_req.data.sample_y[7:0];
            r_fz <= i_req.data.sample_z[7:0];
        end
        if (out_fire) begin
            r_out.out_channel <= r_ch;
            r_out.out_value   <= yz_res;
            r_out.out_last    <= ch_last;
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= 4'd0;
            r_ch   <= 2'd0;
        end else if (req_fire && i_req.data.cmd == CMD_SAMPLE) begin
            r_busy <= 1'b1;
            r_step <= 4'd0;
            r_ch   <= 2'd0;
        end else if (r_busy) begin
            if (!is_z) begin
                r_step <= r_step + 4'd1;
            end else if (out_fire) begin
                r_step <= 4'd0;
                if (ch_last) begin
                    r_busy <= 1'b0;
                end else begin
                    r_ch <= r_ch + 2'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_fire) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_rsp.valid = r_out_valid;
    assign o_rsp.data  = r_out;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vol_width  <= RST_VOL_DIM;
            r_vol_height <= RST_VOL_DIM;
            r_vol_depth  <= RST_VOL_DIM;
            r_num_ch     <= RST_NUM_CHANNELS;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                CFG_VOL_WIDTH:    r_vol_width  <= i_cfg.data;
                CFG_VOL_HEIGHT:   r_vol_height <= i_cfg.data;
                CFG_VOL_DEPTH:    r_vol_depth  <= i_cfg.data;
                CFG_NUM_CHANNELS: r_num_ch     <= i_cfg.data[2:0];
                default: begin
                end
            endcase
        end
    end

    a_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_step <= STEP_Z)
        else $error("step counter out of range");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && is_z && r_out_valid && !o_rsp.ready)
            |=> (r_busy && r_step == STEP_Z && $stable(r_ch)))
        else $error("channel advanced while output stalled");

    a_sample_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (req_fire && i_req.data.cmd == CMD_SAMPLE)
            |=> (r_busy && r_step == 4'd0 && r_ch == 2'd0))
        else $error("sample did not start on channel zero");

    a_done_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && $fell(r_busy)) |-> (r_out_valid && r_out.out_last))
        else $error("sample ended without a last response");

endmodule

FILE: dv/trilinear_volume_sampler_core_test.sv
`timescale 1ns / 1ps

module trilinear_volume_sampler_core_test;

    import tvs_pkg::*;

    localparam int QUIET_LIMIT = 2000;
    localparam int SETTLE_CYCLES = 16;
    localparam int STORE_DEPTH = DEF_MAX_CHANNELS * DEF_MAX_DEPTH * DEF_MAX_HEIGHT * DEF_MAX_WIDTH;

    class sample_scoreboard;
        logic signed [15:0] voxels [STORE_DEPTH];
        logic [5:0] dim_reg [3];
        logic [2:0] lane_reg;
        t_rsp expected_q [$];
        int errors;

        function new();
            dim_reg[0] = RST_VOL_DIM;
            dim_reg[1] = RST_VOL_DIM;
            dim_reg[2] = RST_VOL_DIM;
            lane_reg = RST_NUM_CHANNELS;
            errors = 0;
        endfunction

        static function int addr_of(int c, int z, int y, int x);
            return ((c * DEF_MAX_DEPTH + z) * DEF_MAX_HEIGHT + y) * DEF_MAX_WIDTH + x;
        endfunction

        function void set_reg(logic [1:0] idx, logic [5:0] val);
            case (idx)
                CFG_VOL_WIDTH: dim_reg[0] = val;
                CFG_VOL_HEIGHT: dim_reg[1] = val;
                CFG_VOL_DEPTH: dim_reg[2] = val;
                CFG_NUM_CHANNELS: lane_reg = val[2:0];
                default: ;
            endcase
        endfunction

        function int extent(int axis);
            int lim;
            lim = (axis == 0) ? DEF_MAX_WIDTH : (axis == 1) ? DEF_MAX_HEIGHT : DEF_MAX_DEPTH;
            return (int'(dim_reg[axis]) > lim) ? lim : int'(dim_reg[axis]);
        endfunction

        function int lanes();
            int lim;
            lim = (DEF_MAX_CHANNELS < RESULT_LIMIT) ? DEF_MAX_CHANNELS : RESULT_LIMIT;
            if (lane_reg == 0) return 1;
            return (int'(lane_reg) > lim) ? lim : int'(lane_reg);
        endfunction

        function bit in_volume(int x, int y, int z);
            return x >= 0 && x < extent(0) && y >= 0 && y < extent(1)
                && z >= 0 && z < extent(2);
        endfunction

        function int corner(int c, int x, int y, int z);
            if (!in_volume(x, y, z)) return 0;
            return voxels[addr_of(c, z, y, x)];
        endfunction

        function int blend(int a, int b, int f);
            int t;
            t = a * (256 - f) + b * f + 128;
            return t >>> 8;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void note_request(t_req r);
            int xlo, ylo, zlo, fx, fy, fz, n;
            int e00, e10, e01, e11, f0, f1, v;
            t_rsp exp_rsp;
            if (r.cmd == CMD_WRITE) begin
                voxels[addr_of(r.voxel_channel, r.voxel_z, r.voxel_y, r.voxel_x)] = r.voxel_value;
                return;
            end
            xlo = $signed(r.sample_x[23:8]);
            ylo = $signed(r.sample_y[23:8]);
            zlo = $signed(r.sample_z[23:8]);
            fx = r.sample_x[7:0];
            fy = r.sample_y[7:0];
            fz = r.sample_z[7:0];
            n = lanes();
            for (int c = 0; c < n; c++) begin
                e00 = blend(corner(c, xlo, ylo, zlo), corner(c, xlo + 1, ylo, zlo), fx);
                e10 = blend(corner(c, xlo, ylo + 1, zlo), corner(c, xlo + 1, ylo + 1, zlo), fx);
                e01 = blend(corner(c, xlo, ylo, zlo + 1), corner(c, xlo + 1, ylo, zlo + 1), fx);
                e11 = blend(corner(c, xlo, ylo + 1, zlo + 1),
                            corner(c, xlo + 1, ylo + 1, zlo + 1), fx);
                f0 = blend(e00, e10, fy);
                f1 = blend(e01, e11, fy);
                v = blend(f0, f1, fz);
                exp_rsp.out_channel = c[1:0];
                exp_rsp.out_value = v[15:0];
                exp_rsp.out_last = (c + 1 == n);
                expected_q.push_back(exp_rsp);
            end
        endfunction

        function void check_result(t_rsp r);
            t_rsp want;
            if (expected_q.size() == 0) begin
                $error("unexpected response channel %0d value %0d", r.out_channel,
                       $signed(r.out_value));
                errors++;
                return;
            end
            want = expected_q.pop_front();
            if (r.out_channel !== want.out_channel) begin
                $error("out_channel expected %0d got %0d", want.out_channel, r.out_channel);
                errors++;
            end
            if (r.out_value !== want.out_value) begin
                $error("out_value expected %0d got %0d", $signed(want.out_value),
                       $signed(r.out_value));
                errors++;
            end
            if (r.out_last !== want.out_last) begin
                $error("out_last expected %0d got %0d", want.out_last, r.out_last);
                errors++;
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    tvs_req_if req_if ();
    tvs_rsp_if rsp_if ();
    tvs_cfg_if cfg_if ();

    trilinear_volume_sampler_core DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if),
        .i_cfg   (cfg_if)
    );

    sample_scoreboard sb;
    bit voxel_seen [STORE_DEPTH];
    int sent;
    int burst_left;
    bit steady;
    int quiet_cycles;
    logic [12:0] stall_mask;
    int stall_pos;

    always #5 i_clk = ~i_clk;

    // response stall pattern, period coprime with the channel schedule
    always @(negedge i_clk) begin
        if (stall_pos == 0) begin
            if ($urandom_range(0, 3) == 0) begin
                stall_mask <= '1;
            end else begin
                stall_mask <= 13'($urandom) | 13'd1;
            end
        end
        rsp_if.ready <= stall_mask[stall_pos];
        stall_pos <= (stall_pos == 12) ? 0 : stall_pos + 1;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)
                || (cfg_if.valid && cfg_if.ready)) begin
                quiet_cycles <= 0;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
            if (req_if.valid && req_if.ready) sb.note_request(req_if.data);
            if (rsp_if.valid && rsp_if.ready) sb.check_result(rsp_if.data);
            if (cfg_if.valid && cfg_if.ready) sb.set_reg(cfg_if.index, cfg_if.data);
            if (quiet_cycles == QUIET_LIMIT) begin
                $display("[trilinear_volume_sampler_core] ERROR");
                $finish;
            end
        end
    end

    function automatic logic signed [15:0] random_value();
        case ($urandom_range(0, 7))
            0: return 16'sh8000;
            1: return 16'sh7fff;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic t_req random_req();
        t_req r;
        r.cmd = 1'($urandom);
        r.voxel_x = 5'($urandom);
        r.voxel_y = 5'($urandom);
        r.voxel_z = 5'($urandom);
        r.voxel_channel = 2'($urandom);
        r.voxel_value = random_value();
        r.sample_x = 24'($urandom);
        r.sample_y = 24'($urandom);
        r.sample_z = 24'($urandom);
        return r;
    endfunction

    function automatic logic [23:0] pick_coord(int span);
        int ip, fr, sel;
        sel = $urandom_range(0, 19);
        fr = (sel < 3) ? 0 : (sel < 5) ? 255 : $urandom_range(0, 255);
        if (sel == 19) return 24'($urandom);
        if (sel >= 14 && span > 4) begin
            ip = span - 3 + $urandom_range(0, 4);
        end else begin
            ip = $urandom_range(0, ((span < 3) ? span : 3) + 2) - 1;
        end
        return {ip[15:0], fr[7:0]};
    endfunction

    task automatic issue(input t_req r);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap = steady ? 0 : $urandom_range(1, 6);
            repeat (gap) begin
                @(negedge i_clk);
                req_if.valid <= 1'b0;
            end
        end
        burst_left--;
        if (r.cmd == CMD_WRITE) begin
            voxel_seen[sample_scoreboard::addr_of(r.voxel_channel, r.voxel_z, r.voxel_y,
                                                  r.voxel_x)] = 1'b1;
        end
        sent++;
        @(negedge i_clk);
        req_if.valid <= 1'b1;
        req_if.data <= r;
        do @(posedge i_clk); while (!req_if.ready);
    endtask

    task automatic put_voxel(input int x, input int y, input int z, input int c,
                             input logic signed [15:0] val);
        t_req r;
        r = random_req();
        r.cmd = CMD_WRITE;
        r.voxel_x = x[4:0];
        r.voxel_y = y[4:0];
        r.voxel_z = z[4:0];
        r.voxel_channel = c[1:0];
        r.voxel_value = val;
        issue(r);
    endtask

    // every corner that the sample will read must hold a written value
    task automatic fill_cell(input t_req s);
        int xlo, ylo, zlo, n;
        xlo = $signed(s.sample_x[23:8]);
        ylo = $signed(s.sample_y[23:8]);
        zlo = $signed(s.sample_z[23:8]);
        n = sb.lanes();
        for (int c = 0; c < n; c++) begin
            for (int k = 0; k < 8; k++) begin
                int x, y, z;
                x = xlo + k[0];
                y = ylo + k[1];
                z = zlo + k[2];
                if (sb.in_volume(x, y, z)
                    && !voxel_seen[sample_scoreboard::addr_of(c, z, y, x)]) begin
                    put_voxel(x, y, z, c, random_value());
                end
            end
        end
    endtask

    task automatic sample_at(input logic [23:0] sx, input logic [23:0] sy,
                             input logic [23:0] sz);
        t_req r;
        r = random_req();
        r.cmd = CMD_SAMPLE;
        r.sample_x = sx;
        r.sample_y = sy;
        r.sample_z = sz;
        fill_cell(r);
        issue(r);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [5:0] val);
        @(negedge i_clk);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data <= val;
        do @(posedge i_clk); while (!cfg_if.ready);
        @(negedge i_clk);
        cfg_if.valid <= 1'b0;
    endtask

    task automatic settle();
        @(negedge i_clk);
        req_if.valid <= 1'b0;
        while (sb.pending() > 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        burst_left = 0;
    endtask

    task automatic run_phase(input int w, input int h, input int d, input int n,
                             input int quota);
        t_req r;
        int start;
        write_reg(CFG_VOL_WIDTH, w[5:0]);
        write_reg(CFG_VOL_HEIGHT, h[5:0]);
        write_reg(CFG_VOL_DEPTH, d[5:0]);
        write_reg(CFG_NUM_CHANNELS, {3'b000, n[2:0]});
        steady = ($urandom_range(0, 3) == 0);
        start = sent;
        while (sent - start < quota) begin
            r = random_req();
            if ($urandom_range(0, 3) == 0) begin
                r.cmd = CMD_WRITE;
                if ($urandom_range(0, 1) && sb.extent(0) > 0 && sb.extent(1) > 0
                    && sb.extent(2) > 0) begin
                    r.voxel_x = 5'($urandom_range(0, sb.extent(0) - 1));
                    r.voxel_y = 5'($urandom_range(0, sb.extent(1) - 1));
                    r.voxel_z = 5'($urandom_range(0, sb.extent(2) - 1));
                    r.voxel_channel = 2'($urandom_range(0, sb.lanes() - 1));
                end
                issue(r);
            end else begin
                sample_at(pick_coord(sb.extent(0)), pick_coord(sb.extent(1)),
                          pick_coord(sb.extent(2)));
            end
        end
        settle();
    endtask

    initial begin
        int plan [7][4];
        plan = '{'{1, 1, 1, 4}, '{2, 3, 4, 2}, '{0, 5, 5, 3}, '{63, 40, 33, 7},
                 '{5, 1, 6, 0}, '{32, 32, 32, 4}, '{3, 3, 3, 5}};
        sb = new();
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        req_if.valid = 1'b0;
        req_if.data = '0;
        rsp_if.ready = 1'b0;
        cfg_if.valid = 1'b0;
        cfg_if.index = '0;
        cfg_if.data = '0;
        stall_mask = '1;
        stall_pos = 0;
        quiet_cycles = 0;
        sent = 0;
        burst_left = 0;
        steady = 1'b0;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: extreme voxels, fractions, edges of the volume
        put_voxel(31, 31, 31, 3, 16'sh8000);
        for (int k = 0; k < 8; k++) begin
            put_voxel(k % 2, (k / 2) % 2, k / 4, 0,
                      ((k % 2) ^ ((k / 2) % 2) ^ (k / 4)) ? 16'sh8000 : 16'sh7fff);
        end
        sample_at(24'h000000, 24'h000000, 24'h000000);
        sample_at(24'h000080, 24'h000080, 24'h000080);
        sample_at(24'h0000ff, 24'h0000ff, 24'h0000ff);
        sample_at(24'h000001, 24'h000000, 24'h0000ff);
        sample_at(24'hffff80, 24'h000080, 24'h000000);
        sample_at(24'h000080, 24'hffffc0, 24'hffff40);
        sample_at(24'h001f80, 24'h001f80, 24'h001f80);
        sample_at(24'h001e80, 24'h001e40, 24'h001ec0);
        sample_at(24'h7fffff, 24'h7fffff, 24'h7fffff);
        sample_at(24'h800000, 24'h800000, 24'h800000);
        settle();

        for (int p = 0; p < 9; p++) begin
            if (p < 7) begin
                run_phase(plan[p][0], plan[p][1], plan[p][2], plan[p][3], 36);
            end else begin
                run_phase($urandom_range(0, 12), $urandom_range(0, 12),
                          $urandom_range(0, 12), $urandom_range(0, 7), 36);
            end
        end

        while (sb.pending() > 0) @(posedge i_clk);
        repeat (30) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("[trilinear_volume_sampler_core] OK");
        end else begin
            $display("[trilinear_volume_sampler_core] ERROR");
        end
        $finish;
    end

endmodule
